/* rtl/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int ORDER_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    // Working order register: must reach the order count itself (up to 16)
    localparam int ORD_W    = 5;

    localparam logic [CFG_W-1:0] TOP_BLOCK_COUNT_RST = 5'd16;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;
    // Unused kind: no state change, answers done with page zero
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SWEEP,
        S_SEARCH,
        S_U_RD,
        S_U_LINK,
        S_U_CLR,
        S_T_RD,
        S_T_WR,
        S_P1,
        S_P2,
        S_I_CHK,
        S_FINISH
    } t_state;

    // Datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT_CLR,
        DP_SWEEP,
        DP_SEARCH,
        DP_UNLINK_RD,
        DP_UNLINK_LINK,
        DP_UNLINK_CLR,
        DP_TOG_RD,
        DP_TOG_WR,
        DP_PUSH1,
        DP_PUSH2,
        DP_INIT_SETUP,
        DP_DONE
    } t_dp_op;

    // Datapath status back to the controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              bad;
        logic              hit;
        logic              at_end;
        logic              at_target;
        logic              merge_ok;
        logic              sweep_last;
        logic              init_done;
    } t_dp_stat;

endpackage

/* rtl/bpa_dp.sv */
// Datapath: free list heads and counts, link memories, pair bit memory, result register.
`timescale 1ns / 1ps

module bpa_dp #(
    parameter int PAGE_INDEX_BITS = 14,
    parameter int ORDER_COUNT     = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_dp_op               i_op,
    output bpa_pkg::t_dp_stat             o_stat,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::ORDER_W-1:0]   i_order,
    input  logic [PAGE_INDEX_BITS-1:0]    i_page_index,
    input  logic [bpa_pkg::CFG_W-1:0]     i_top_block_count,
    output logic                          o_valid,
    output logic [bpa_pkg::STATUS_W-1:0]  o_status,
    output logic [PAGE_INDEX_BITS-1:0]    o_block_page
);

    localparam int P     = PAGE_INDEX_BITS;
    localparam int PAGES = 1 << P;
    localparam int OI_W  = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
    localparam logic [P:0] NIL = {1'b1, {P{1'b0}}};
    localparam logic [P:0] FIT = NIL >> (ORDER_COUNT - 1);
    localparam logic [bpa_pkg::ORD_W-1:0] OC_V  = bpa_pkg::ORD_W'(ORDER_COUNT);
    localparam logic [bpa_pkg::ORD_W-1:0] TOP_O = bpa_pkg::ORD_W'(ORDER_COUNT - 1);
    localparam logic [P-1:0] ONE = P'(1);

    // List heads and counts per order
    logic [P:0] r_head  [ORDER_COUNT];
    logic [P:0] r_count [ORDER_COUNT];

    // Link and pair memories
    logic [P:0] r_next_mem [PAGES];
    logic [P:0] r_prev_mem [PAGES];
    logic       r_pair_mem [PAGES];
    logic [P:0] r_next_rd;
    logic [P:0] r_prev_rd;
    logic       r_pair_rd;

    // Working registers
    logic [bpa_pkg::KIND_W-1:0]   r_kind;
    logic [bpa_pkg::ORDER_W-1:0]  r_order;
    logic [bpa_pkg::ORD_W-1:0]    r_o;
    logic [P-1:0]                 r_blk;
    logic [P-1:0]                 r_node;
    logic [P-1:0]                 r_sweep;
    logic [bpa_pkg::CFG_W-1:0]    r_i;
    logic [bpa_pkg::STATUS_W-1:0] r_status;
    logic                         r_out_valid;
    logic [bpa_pkg::STATUS_W-1:0] r_out_status;
    logic [P-1:0]                 r_out_block;

    logic [OI_W-1:0] oi;
    logic [P:0]      cur_head;
    logic [P:0]      cur_count;
    logic            in_range;
    logic            at_target;
    logic [P:0]      pair_base;
    logic [P-1:0]    pair_idx;

    logic         next_we;
    logic [P-1:0] next_wa;
    logic [P:0]   next_wd;
    logic         prev_we;
    logic [P-1:0] prev_wa;
    logic [P:0]   prev_wd;
    logic         pair_we;
    logic [P-1:0] pair_wa;
    logic         pair_wd;

    // Decode current order and pair bit address
    always_comb begin
        oi        = r_o[OI_W-1:0];
        in_range  = r_o < OC_V;
        cur_head  = r_head[oi];
        cur_count = r_count[oi];
        at_target = r_o == {1'b0, r_order};
        pair_base = NIL - (NIL >> r_o);
        pair_idx  = P'(pair_base + (P+1)'(r_blk >> (r_o + bpa_pkg::ORD_W'(1))));
    end

    // Report status to the controller
    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.bad        = r_status != bpa_pkg::ST_OK;
        o_stat.hit        = in_range && (cur_count != '0) && (cur_head < NIL);
        o_stat.at_end     = !in_range;
        o_stat.at_target  = at_target;
        // Pair bit read as one toggles to zero: buddy is free, merge
        o_stat.merge_ok   = r_pair_rd && ((r_o + bpa_pkg::ORD_W'(1)) < OC_V);
        o_stat.sweep_last = &r_sweep;
        o_stat.init_done  = (r_i >= i_top_block_count) || ((P+1)'(r_i) >= FIT);
    end

    // Drive link and pair memory write ports
    always_comb begin
        next_we = 1'b0;
        next_wa = r_blk;
        next_wd = cur_head;
        prev_we = 1'b0;
        prev_wa = r_blk;
        prev_wd = NIL;
        pair_we = 1'b0;
        pair_wa = pair_idx;
        pair_wd = !r_pair_rd;
        case (i_op)
            bpa_pkg::DP_PUSH1: begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            bpa_pkg::DP_PUSH2: begin
                prev_we = cur_head < NIL;
                prev_wa = cur_head[P-1:0];
                prev_wd = {1'b0, r_blk};
            end
            bpa_pkg::DP_UNLINK_LINK: begin
                next_we = r_prev_rd < NIL;
                next_wa = r_prev_rd[P-1:0];
                next_wd = r_next_rd;
                prev_we = r_next_rd < NIL;
                prev_wa = r_next_rd[P-1:0];
                prev_wd = r_prev_rd;
            end
            bpa_pkg::DP_UNLINK_CLR: begin
                next_we = 1'b1;
                next_wa = r_node;
                next_wd = NIL;
                prev_we = 1'b1;
                prev_wa = r_node;
            end
            bpa_pkg::DP_TOG_WR: begin
                pair_we = 1'b1;
            end
            bpa_pkg::DP_SWEEP: begin
                pair_we = 1'b1;
                pair_wa = r_sweep;
                pair_wd = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Link memories with registered read
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (i_op == bpa_pkg::DP_UNLINK_RD) begin
            r_next_rd <= r_next_mem[r_node];
            r_prev_rd <= r_prev_mem[r_node];
        end
    end

    // Pair bit memory with registered read
    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            r_pair_mem[pair_wa] <= pair_wd;
        end
        if (i_op == bpa_pkg::DP_TOG_RD) begin
            r_pair_rd <= r_pair_mem[pair_idx];
        end
    end

    // Execute datapath commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ORDER_COUNT; k++) begin
                r_head[k]  <= NIL;
                r_count[k] <= '0;
            end
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (i_op)
                bpa_pkg::DP_LOAD: begin
                    r_kind  <= i_kind;
                    r_order <= i_order;
                    r_o     <= {1'b0, i_order};
                    r_blk   <= i_page_index & ({P{1'b1}} << i_order);
                    r_i     <= '0;
                    if ((i_kind == bpa_pkg::KIND_ALLOC || i_kind == bpa_pkg::KIND_FREE)
                        && ({1'b0, i_order} >= OC_V)) begin
                        r_status <= bpa_pkg::ST_RANGE;
                    end else begin
                        r_status <= bpa_pkg::ST_OK;
                    end
                end
                bpa_pkg::DP_INIT_CLR: begin
                    for (int k = 0; k < ORDER_COUNT; k++) begin
                        r_head[k]  <= NIL;
                        r_count[k] <= '0;
                    end
                end
                bpa_pkg::DP_SWEEP: begin
                    r_sweep <= r_sweep + ONE;
                end
                bpa_pkg::DP_SEARCH: begin
                    if (o_stat.hit) begin
                        r_blk  <= cur_head[P-1:0];
                        r_node <= cur_head[P-1:0];
                    end else if (!in_range) begin
                        r_status <= bpa_pkg::ST_OOM;
                    end else begin
                        r_o <= r_o + bpa_pkg::ORD_W'(1);
                    end
                end
                bpa_pkg::DP_UNLINK_LINK: begin
                    if (!(r_prev_rd < NIL) && cur_head == {1'b0, r_node}) begin
                        r_head[oi] <= r_next_rd;
                    end
                    if (cur_count != '0) begin
                        r_count[oi] <= cur_count - (P+1)'(1);
                    end
                end
                bpa_pkg::DP_UNLINK_CLR: begin
                    // Merge with the buddy just taken off its list
                    if (r_kind == bpa_pkg::KIND_FREE) begin
                        if (r_node < r_blk) begin
                            r_blk <= r_node;
                        end
                        r_o <= r_o + bpa_pkg::ORD_W'(1);
                    end
                end
                bpa_pkg::DP_TOG_WR: begin
                    r_node <= r_blk ^ (ONE << r_o);
                    if (r_kind == bpa_pkg::KIND_ALLOC && !at_target) begin
                        r_o <= r_o - bpa_pkg::ORD_W'(1);
                    end
                end
                bpa_pkg::DP_PUSH2: begin
                    r_head[oi]  <= {1'b0, r_blk};
                    r_count[oi] <= cur_count + (P+1)'(1);
                    // Split: continue with the upper half
                    if (r_kind == bpa_pkg::KIND_ALLOC) begin
                        r_blk <= r_blk + (ONE << r_o);
                    end
                end
                bpa_pkg::DP_INIT_SETUP: begin
                    r_blk <= P'({{P{1'b0}}, r_i} << (ORDER_COUNT - 1));
                    r_o   <= TOP_O;
                    r_i   <= r_i + bpa_pkg::CFG_W'(1);
                end
                bpa_pkg::DP_DONE: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= r_status;
                    if (r_kind == bpa_pkg::KIND_ALLOC && r_status == bpa_pkg::ST_OK) begin
                        r_out_block <= r_blk;
                    end else begin
                        r_out_block <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_block_page = r_out_block;

endmodule

/* rtl/bpa_ctrl.sv */
// Controller state machine sequencing the allocator datapath.
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  bpa_pkg::t_dp_stat i_stat,
    output bpa_pkg::t_dp_op   o_op
);

    bpa_pkg::t_state r_state;
    bpa_pkg::t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance state and issue commands
    always_comb begin
        n_state = r_state;
        o_op    = bpa_pkg::DP_NOP;
        o_busy  = 1'b1;
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                o_op = bpa_pkg::DP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_op    = bpa_pkg::DP_LOAD;
                    n_state = bpa_pkg::S_DISPATCH;
                end
            end
            bpa_pkg::S_DISPATCH: begin
                if (i_stat.bad) begin
                    n_state = bpa_pkg::S_FINISH;
                end else if (i_stat.kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = bpa_pkg::S_SEARCH;
                end else if (i_stat.kind == bpa_pkg::KIND_FREE) begin
                    n_state = bpa_pkg::S_T_RD;
                end else if (i_stat.kind == bpa_pkg::KIND_INIT) begin
                    o_op    = bpa_pkg::DP_INIT_CLR;
                    n_state = bpa_pkg::S_SWEEP;
                end else begin
                    n_state = bpa_pkg::S_FINISH;
                end
            end
            bpa_pkg::S_SWEEP: begin
                o_op = bpa_pkg::DP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = bpa_pkg::S_I_CHK;
                end
            end
            bpa_pkg::S_SEARCH: begin
                o_op = bpa_pkg::DP_SEARCH;
                if (i_stat.hit) begin
                    n_state = bpa_pkg::S_U_RD;
                end else if (i_stat.at_end) begin
                    n_state = bpa_pkg::S_FINISH;
                end
            end
            bpa_pkg::S_U_RD: begin
                o_op    = bpa_pkg::DP_UNLINK_RD;
                n_state = bpa_pkg::S_U_LINK;
            end
            bpa_pkg::S_U_LINK: begin
                o_op    = bpa_pkg::DP_UNLINK_LINK;
                n_state = bpa_pkg::S_U_CLR;
            end
            bpa_pkg::S_U_CLR: begin
                o_op    = bpa_pkg::DP_UNLINK_CLR;
                n_state = bpa_pkg::S_T_RD;
            end
            bpa_pkg::S_T_RD: begin
                o_op    = bpa_pkg::DP_TOG_RD;
                n_state = bpa_pkg::S_T_WR;
            end
            bpa_pkg::S_T_WR: begin
                o_op = bpa_pkg::DP_TOG_WR;
                if (i_stat.kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = i_stat.at_target ? bpa_pkg::S_FINISH : bpa_pkg::S_P1;
                end else begin
                    n_state = i_stat.merge_ok ? bpa_pkg::S_U_RD : bpa_pkg::S_P1;
                end
            end
            bpa_pkg::S_P1: begin
                o_op    = bpa_pkg::DP_PUSH1;
                n_state = bpa_pkg::S_P2;
            end
            bpa_pkg::S_P2: begin
                o_op = bpa_pkg::DP_PUSH2;
                if (i_stat.kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = bpa_pkg::S_T_RD;
                end else if (i_stat.kind == bpa_pkg::KIND_FREE) begin
                    n_state = bpa_pkg::S_FINISH;
                end else begin
                    n_state = bpa_pkg::S_I_CHK;
                end
            end
            bpa_pkg::S_I_CHK: begin
                if (i_stat.init_done) begin
                    n_state = bpa_pkg::S_FINISH;
                end else begin
                    o_op    = bpa_pkg::DP_INIT_SETUP;
                    n_state = bpa_pkg::S_P1;
                end
            end
            bpa_pkg::S_FINISH: begin
                o_op    = bpa_pkg::DP_DONE;
                n_state = bpa_pkg::S_IDLE;
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/buddy_page_allocator_core.sv */
// Buddy page allocator top level: configuration register, controller and datapath.
// After reset the block sweeps the pair bit memory clear, one entry per cycle, with busy
// high. A transaction is taken when start is high and busy low; busy then stays high
// and the single result leaves as a one-cycle o_valid strobe in the same cycle that
// busy falls, which cannot be stalled. A range error or the unused kind goes straight
// to the result; an allocate searches up from its own order, takes the block found off
// its list and splits it back down; an out of memory allocate ends after searching past
// the top order; free merges with each free buddy; initialize clears the pair bits and
// then pushes each top block. The steps are set by the single-port link and pair memories.
`timescale 1ns / 1ps

module buddy_page_allocator_core #(
    parameter int PAGE_INDEX_BITS = 14,
    parameter int ORDER_COUNT     = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::ORDER_W-1:0]   i_order,
    input  logic [PAGE_INDEX_BITS-1:0]    i_page_index,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                          o_valid,
    output logic [bpa_pkg::STATUS_W-1:0]  o_status,
    output logic [PAGE_INDEX_BITS-1:0]    o_block_page
);

    logic [bpa_pkg::CFG_W-1:0] r_top_block_count;
    bpa_pkg::t_dp_op           dp_op;
    bpa_pkg::t_dp_stat         dp_stat;

    // Hold the top block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_block_count <= bpa_pkg::TOP_BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            r_top_block_count <= i_cfg_wdata;
        end
    end

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (dp_stat),
        .o_op    (dp_op)
    );

    bpa_dp #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS),
        .ORDER_COUNT     (ORDER_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (dp_op),
        .o_stat            (dp_stat),
        .i_kind            (i_kind),
        .i_order           (i_order),
        .i_page_index      (i_page_index),
        .i_top_block_count (r_top_block_count),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_block_page      (o_block_page)
    );

    // An accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // A result only follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // Failed results carry page zero; the datapath also zeroes it for non-allocating kinds
    a_fail_zero_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bpa_pkg::ST_OK) |-> (o_block_page == '0))
        else $error("nonzero page on failed result");

endmodule
